// File: sv/bmb_pkg.sv
// Shared types and constants for the mono page bitmap blitter.
// Image geometry, item kinds, register indexes and cursor interface structs.
// No dependencies.
`default_nettype none

package bmb_pkg;

  // Image geometry
  localparam int IMAGE_WIDTH  = 128;
  localparam int IMAGE_HEIGHT = 97;
  localparam int IMAGE_PAGES  = (IMAGE_HEIGHT + 7) / 8;
  localparam int IMAGE_BYTES  = IMAGE_PAGES * IMAGE_WIDTH;
  localparam int RAM_AW       = $clog2(IMAGE_BYTES);

  // Field widths
  localparam int KIND_W = 2;
  localparam int COL_W  = 8;
  localparam int ROW_W  = 7;
  localparam int BITS_W = 8;
  localparam int CNT_W  = 4;
  localparam int ADDR_W = 11;
  localparam int DATA_W = 8;
  localparam int CFG_IW = 2;

  localparam int S_TDATA_W = 64;
  localparam int S_TUSER_W = KIND_W;
  localparam int M_TDATA_W = 16;

  // Item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_START  = 2'd0,
    KIND_BITMAP = 2'd1,
    KIND_STORE  = 2'd2,
    KIND_LOAD   = 2'd3
  } kind_e;

  // Register indexes
  localparam logic [CFG_IW-1:0] CFG_PAL_ZERO  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_PAL_ONE   = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_OVERWRITE = 2'd2;

  // Cursor command: open a rectangle or advance one pixel
  typedef struct packed {
    logic             start;
    logic             step;
    logic [COL_W-1:0] origin_col;
    logic [ROW_W-1:0] origin_row;
    logic [COL_W-1:0] rect_cols;
    logic [ROW_W-1:0] rect_rows;
  } cur_cmd_t;

  // Cursor status: current pixel location and drawing state
  typedef struct packed {
    logic [RAM_AW-1:0] addr;
    logic [2:0]        bit_pos;
    logic              drawing;
    logic              last_pixel;
  } cur_sts_t;

endpackage

`default_nettype wire

// File: sv/bmb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module bmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds when idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: sv/bmb_cursor.sv
// Rectangle cursor: clips a new rectangle to the image and walks it pixel
// by pixel in raster order. Depends on bmb_pkg.
`default_nettype none

module bmb_cursor (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bmb_pkg::cur_cmd_t cmd_i,
  output bmb_pkg::cur_sts_t      sts_o
);

  logic [bmb_pkg::COL_W-1:0] left_col_q, left_col_d;
  logic [bmb_pkg::COL_W-1:0] cur_col_q, cur_col_d;
  logic [bmb_pkg::ROW_W-1:0] cur_row_q, cur_row_d;
  logic [bmb_pkg::COL_W-1:0] span_cols_q, span_cols_d;
  logic [bmb_pkg::ROW_W-1:0] rows_left_q, rows_left_d;

  logic                      origin_ok;
  logic [bmb_pkg::COL_W:0]   col_end;
  logic [bmb_pkg::ROW_W:0]   row_end;
  logic [bmb_pkg::COL_W-1:0] cols_clip;
  logic [bmb_pkg::ROW_W-1:0] rows_clip;
  logic [bmb_pkg::COL_W:0]   col_next;
  logic [bmb_pkg::COL_W:0]   right_edge;
  logic                      wrap;

  // clip the requested rectangle to the image
  always_comb begin
    origin_ok = ({1'b0, cmd_i.origin_col} < (bmb_pkg::COL_W+1)'(bmb_pkg::IMAGE_WIDTH)) &&
                ({1'b0, cmd_i.origin_row} < (bmb_pkg::ROW_W+1)'(bmb_pkg::IMAGE_HEIGHT));
    col_end = {1'b0, cmd_i.origin_col} + {1'b0, cmd_i.rect_cols};
    row_end = {1'b0, cmd_i.origin_row} + {1'b0, cmd_i.rect_rows};
    if (col_end > (bmb_pkg::COL_W+1)'(bmb_pkg::IMAGE_WIDTH)) begin
      cols_clip = bmb_pkg::COL_W'((bmb_pkg::COL_W+1)'(bmb_pkg::IMAGE_WIDTH) -
                                  {1'b0, cmd_i.origin_col});
    end else begin
      cols_clip = cmd_i.rect_cols;
    end
    if (row_end > (bmb_pkg::ROW_W+1)'(bmb_pkg::IMAGE_HEIGHT)) begin
      rows_clip = bmb_pkg::ROW_W'((bmb_pkg::ROW_W+1)'(bmb_pkg::IMAGE_HEIGHT) -
                                  {1'b0, cmd_i.origin_row});
    end else begin
      rows_clip = cmd_i.rect_rows;
    end
  end

  // raster advance: wrap to the left edge at the end of a row
  always_comb begin
    col_next   = {1'b0, cur_col_q} + (bmb_pkg::COL_W+1)'(1);
    right_edge = {1'b0, left_col_q} + {1'b0, span_cols_q};
    wrap       = (col_next >= right_edge);
  end

  // next state
  always_comb begin
    left_col_d  = left_col_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    span_cols_d = span_cols_q;
    rows_left_d = rows_left_q;
    if (cmd_i.start) begin
      if (origin_ok) begin
        left_col_d  = cmd_i.origin_col;
        cur_col_d   = cmd_i.origin_col;
        cur_row_d   = cmd_i.origin_row;
        span_cols_d = cols_clip;
        rows_left_d = (cols_clip == '0) ? '0 : rows_clip;
      end else begin
        rows_left_d = '0;
      end
    end else if (cmd_i.step) begin
      if (wrap) begin
        cur_col_d   = left_col_q;
        cur_row_d   = cur_row_q + bmb_pkg::ROW_W'(1);
        rows_left_d = rows_left_q - bmb_pkg::ROW_W'(1);
      end else begin
        cur_col_d = col_next[bmb_pkg::COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_col_q  <= '0;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      span_cols_q <= '0;
      rows_left_q <= '0;
    end else begin
      left_col_q  <= left_col_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      span_cols_q <= span_cols_d;
      rows_left_q <= rows_left_d;
    end
  end

  // byte address of the current pixel: page * width + column
  always_comb begin
    sts_o.addr = bmb_pkg::RAM_AW'(bmb_pkg::RAM_AW'(cur_row_q >> 3) *
                                  bmb_pkg::RAM_AW'(bmb_pkg::IMAGE_WIDTH) +
                                  bmb_pkg::RAM_AW'(cur_col_q));
    sts_o.bit_pos    = cur_row_q[2:0];
    sts_o.drawing    = (rows_left_q != '0);
    sts_o.last_pixel = wrap && (rows_left_q == bmb_pkg::ROW_W'(1));
  end

  // a live rectangle always stays inside the image
  a_row_in_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rows_left_q != '0) |-> ({1'b0, cur_row_q} < (bmb_pkg::ROW_W+1)'(bmb_pkg::IMAGE_HEIGHT)))
    else $error("cursor row outside image while drawing");

  a_col_in_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rows_left_q != '0) |-> ({1'b0, cur_col_q} < (bmb_pkg::COL_W+1)'(bmb_pkg::IMAGE_WIDTH)))
    else $error("cursor column outside image while drawing");

  a_col_in_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rows_left_q != '0) |-> (cur_col_q >= left_col_q))
    else $error("cursor column left of rectangle");

endmodule

`default_nettype wire

// File: sv/mono_page_bitmap_blitter_core.sv
// Mono page bitmap blitter: top level with item control, pixel
// read-modify-write pipeline and framebuffer RAM. Depends on bmb_pkg,
// bmb_ram and bmb_cursor.
//
// Draws 1-bit bitmaps into a page-organized monochrome framebuffer held in
// one RAM (IMAGE_PAGES * IMAGE_WIDTH bytes, one read and one write port).
// Items are taken only in the idle state, and each leaves through the final
// state: a load item first passes a read-wait state, and a bitmap item
// paints 0 to 8 pixels in the draw state. Pixels stream at one per
// cycle through the RAM read port: the read of one pixel overlaps the write
// of the one before, and a one-entry forwarding register covers the case
// where both hit the same byte. Each result sits in an output register, so
// the next item is taken while it waits. Image bytes are undefined after
// reset until written.
`default_nettype none

module mono_page_bitmap_blitter_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration write port
  input  wire logic                            cfg_we_i,
  input  wire logic [bmb_pkg::CFG_IW-1:0]      cfg_idx_i,
  input  wire logic                            cfg_wdata_i,
  // input items
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // origin_col[7:0], origin_row[14:8], rect_cols[22:15], rect_rows[29:23],
  // bitmap_bits[37:30], bit_count[41:38], image_addr[52:42],
  // image_wdata[60:53], zero pad[63:61]
  input  wire logic [bmb_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // kind[1:0]
  input  wire logic [bmb_pkg::S_TUSER_W-1:0]   s_axis_tuser,
  // result items
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // read_data[7:0], drawing[8], zero pad[15:9]
  output logic      [bmb_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DRAW  = 2'd1;
  localparam logic [1:0] ST_LOADW = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  // input fields
  bmb_pkg::kind_e             in_kind;
  logic [bmb_pkg::COL_W-1:0]  in_origin_col;
  logic [bmb_pkg::ROW_W-1:0]  in_origin_row;
  logic [bmb_pkg::COL_W-1:0]  in_rect_cols;
  logic [bmb_pkg::ROW_W-1:0]  in_rect_rows;
  logic [bmb_pkg::BITS_W-1:0] in_bitmap_bits;
  logic [bmb_pkg::CNT_W-1:0]  in_bit_count;
  logic [bmb_pkg::ADDR_W-1:0] in_image_addr;
  logic [bmb_pkg::DATA_W-1:0] in_image_wdata;

  logic [1:0]                 state_q, state_d;
  logic                       pal_zero_q, pal_one_q, overwrite_q;
  logic [bmb_pkg::BITS_W-1:0] bits_q, bits_d;
  logic [bmb_pkg::CNT_W-1:0]  count_q, count_d;
  logic [bmb_pkg::CNT_W-1:0]  bit_idx_q, bit_idx_d;
  logic                       load_hit_q, load_hit_d;
  logic [bmb_pkg::DATA_W-1:0] res_data_q, res_data_d;
  logic                       m_valid_q, m_valid_d;
  logic [bmb_pkg::M_TDATA_W-1:0] m_data_q, m_data_d;

  // write stage of the pixel pipeline
  logic                       p2_valid_q, p2_valid_d;
  logic [bmb_pkg::RAM_AW-1:0] p2_addr_q, p2_addr_d;
  logic [2:0]                 p2_bit_q, p2_bit_d;
  logic                       p2_paint_q, p2_paint_d;
  // last pixel write, for forwarding
  logic                       fwd_valid_q;
  logic [bmb_pkg::RAM_AW-1:0] fwd_addr_q;
  logic [bmb_pkg::DATA_W-1:0] fwd_data_q;

  logic                       accept;
  logic                       addr_ok;
  logic [bmb_pkg::CNT_W-1:0]  count_clip;
  logic                       cur_bit;
  logic                       last_issue;
  logic [bmb_pkg::DATA_W-1:0] pix_base;
  logic [bmb_pkg::DATA_W-1:0] pix_mask;
  logic [bmb_pkg::DATA_W-1:0] pix_new;

  bmb_pkg::cur_cmd_t          cur_cmd;
  bmb_pkg::cur_sts_t          cur_sts;

  logic                       ram_we;
  logic [bmb_pkg::RAM_AW-1:0] ram_waddr;
  logic [bmb_pkg::DATA_W-1:0] ram_wdata;
  logic                       ram_re;
  logic [bmb_pkg::RAM_AW-1:0] ram_raddr;
  logic [bmb_pkg::DATA_W-1:0] ram_rdata;

  // unpack the input item
  always_comb begin
    in_kind        = bmb_pkg::kind_e'(s_axis_tuser[1:0]);
    in_origin_col  = s_axis_tdata[7:0];
    in_origin_row  = s_axis_tdata[14:8];
    in_rect_cols   = s_axis_tdata[22:15];
    in_rect_rows   = s_axis_tdata[29:23];
    in_bitmap_bits = s_axis_tdata[37:30];
    in_bit_count   = s_axis_tdata[41:38];
    in_image_addr  = s_axis_tdata[52:42];
    in_image_wdata = s_axis_tdata[60:53];
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign addr_ok       = ({1'b0, in_image_addr} < (bmb_pkg::ADDR_W+1)'(bmb_pkg::IMAGE_BYTES));
  assign count_clip    = (in_bit_count > bmb_pkg::CNT_W'(8)) ? bmb_pkg::CNT_W'(8) : in_bit_count;
  assign cur_bit       = bits_q[bit_idx_q[2:0]];
  assign last_issue    = ((bit_idx_q + bmb_pkg::CNT_W'(1)) == count_q) || cur_sts.last_pixel;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_zero_q  <= 1'b0;
      pal_one_q   <= 1'b1;
      overwrite_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bmb_pkg::CFG_PAL_ZERO:  pal_zero_q  <= cfg_wdata_i;
        bmb_pkg::CFG_PAL_ONE:   pal_one_q   <= cfg_wdata_i;
        bmb_pkg::CFG_OVERWRITE: overwrite_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // modify stage: merge the pixel into the byte read last cycle
  always_comb begin
    pix_base = (fwd_valid_q && (fwd_addr_q == p2_addr_q)) ? fwd_data_q : ram_rdata;
    pix_mask = bmb_pkg::DATA_W'(1) << p2_bit_q;
    if (overwrite_q) begin
      pix_new = p2_paint_q ? (pix_base | pix_mask) : (pix_base & ~pix_mask);
    end else begin
      pix_new = p2_paint_q ? (pix_base ^ pix_mask) : pix_base;
    end
  end

  // item control
  always_comb begin
    state_d    = state_q;
    bits_d     = bits_q;
    count_d    = count_q;
    bit_idx_d  = bit_idx_q;
    load_hit_d = load_hit_q;
    res_data_d = res_data_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_data_d   = m_data_q;
    p2_valid_d = 1'b0;
    p2_addr_d  = p2_addr_q;
    p2_bit_d   = p2_bit_q;
    p2_paint_d = p2_paint_q;

    cur_cmd.start      = 1'b0;
    cur_cmd.step       = 1'b0;
    cur_cmd.origin_col = in_origin_col;
    cur_cmd.origin_row = in_origin_row;
    cur_cmd.rect_cols  = in_rect_cols;
    cur_cmd.rect_rows  = in_rect_rows;

    ram_re    = 1'b0;
    ram_raddr = cur_sts.addr;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_data_d = '0;
          unique case (in_kind)
            bmb_pkg::KIND_START: begin
              cur_cmd.start = 1'b1;
              state_d       = ST_FIN;
            end
            bmb_pkg::KIND_BITMAP: begin
              bits_d    = in_bitmap_bits;
              count_d   = count_clip;
              bit_idx_d = '0;
              state_d   = (cur_sts.drawing && (count_clip != '0)) ? ST_DRAW : ST_FIN;
            end
            bmb_pkg::KIND_STORE: begin
              state_d = ST_FIN;
            end
            bmb_pkg::KIND_LOAD: begin
              ram_re     = addr_ok;
              ram_raddr  = bmb_pkg::RAM_AW'(in_image_addr);
              load_hit_d = addr_ok;
              state_d    = ST_LOADW;
            end
            default: state_d = ST_FIN;
          endcase
        end
      end
      ST_DRAW: begin
        // read the current pixel's byte and move the cursor on
        ram_re       = 1'b1;
        cur_cmd.step = 1'b1;
        p2_valid_d   = 1'b1;
        p2_addr_d    = cur_sts.addr;
        p2_bit_d     = cur_sts.bit_pos;
        p2_paint_d   = cur_bit ? pal_one_q : pal_zero_q;
        bit_idx_d    = bit_idx_q + bmb_pkg::CNT_W'(1);
        if (last_issue) begin
          state_d = ST_FIN;
        end
      end
      ST_LOADW: begin
        res_data_d = load_hit_q ? ram_rdata : '0;
        state_d    = ST_FIN;
      end
      ST_FIN: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {(bmb_pkg::M_TDATA_W-bmb_pkg::DATA_W-1)'(0), cur_sts.drawing, res_data_q};
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // write port: direct store or pixel write-back
  always_comb begin
    if (p2_valid_q) begin
      ram_we    = 1'b1;
      ram_waddr = p2_addr_q;
      ram_wdata = pix_new;
    end else begin
      ram_we    = accept && (in_kind == bmb_pkg::KIND_STORE) && addr_ok;
      ram_waddr = bmb_pkg::RAM_AW'(in_image_addr);
      ram_wdata = in_image_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      m_valid_q   <= 1'b0;
      p2_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      m_valid_q   <= m_valid_d;
      p2_valid_q  <= p2_valid_d;
      fwd_valid_q <= p2_valid_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    bits_q     <= bits_d;
    count_q    <= count_d;
    bit_idx_q  <= bit_idx_d;
    load_hit_q <= load_hit_d;
    res_data_q <= res_data_d;
    m_data_q   <= m_data_d;
    p2_addr_q  <= p2_addr_d;
    p2_bit_q   <= p2_bit_d;
    p2_paint_q <= p2_paint_d;
    fwd_addr_q <= p2_addr_q;
    fwd_data_q <= pix_new;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  bmb_cursor u_cursor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cur_cmd),
    .sts_o  (cur_sts)
  );

  bmb_ram #(
    .WIDTH (bmb_pkg::DATA_W),
    .DEPTH (bmb_pkg::IMAGE_BYTES)
  ) u_image_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // a pixel write-back always follows a read issued in the draw state
  a_p2_after_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p2_valid_q |-> ($past(state_q) == ST_DRAW))
    else $error("pixel write-back without a preceding read");

  // no item is taken while a pixel write is still pending
  a_no_accept_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !p2_valid_q)
    else $error("item accepted with a pixel write in flight");

  // the draw state only runs on a live rectangle
  a_draw_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAW) |-> cur_sts.drawing)
    else $error("drawing with no rows left");

  // never more pixels than the item carries
  a_bit_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAW) |-> (bit_idx_q < count_q))
    else $error("bit index past bit count");

endmodule

`default_nettype wire
